### rtl/caliper_frame_decoder_defines.svh
// Assertion macros; clk and arst_n are taken from the scope of use.
`ifndef CALIPER_FRAME_DECODER_DEFINES_SVH
`define CALIPER_FRAME_DECODER_DEFINES_SVH

// same-cycle implication
`define CFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfd assertion failed");

// next-cycle implication
`define CFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfd assertion failed");

`endif

### rtl/cfd_pkg.sv
package cfd_pkg;

	localparam int unsigned WORD_BITS_DEF = 32;
	localparam int unsigned MAG_BITS      = 20;
	localparam int unsigned SIGN_BIT      = 20;
	localparam int unsigned INCH_BIT      = 23;
	localparam int unsigned INCH_NUM      = 254;
	localparam int unsigned INCH_DEN      = 200;
	// x/200 = (x>>3)/25
	localparam int unsigned PRE_SHIFT     = 3;
	localparam int unsigned DIV_REST      = INCH_DEN >> PRE_SHIFT;
	localparam int unsigned RECIP_SHIFT   = 32;
	localparam longint unsigned RECIP     = (64'd1 << RECIP_SHIFT) / DIV_REST;

	localparam int unsigned PROD_W   = 28;
	localparam int unsigned DIVIN_W  = PROD_W - PRE_SHIFT;
	localparam int unsigned SCALED_W = 21;

	localparam int unsigned GAP_W     = 31;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [GAP_W-1:0]  GAP_RESET = 31'd90000;
	localparam logic [DATA_W-1:0] ERR_RESET = 32'h8000_0000;

	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAP = 2'd0,
		REG_ERR = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic        data_bit;
		logic [31:0] timestamp_us;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] position_um;
		logic [31:0]        frame_time_us;
		logic               out_of_range;
	} out_item_t;

	typedef struct packed {
		logic                top_bit;
		logic                inch;
		logic                sign;
		logic [MAG_BITS-1:0] mag;
		logic [31:0]         time_us;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

### rtl/cfd_stream_if.sv
interface cfd_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### rtl/caliper_frame_decoder.sv
// Caliper frame decoder. Each input beat is one falling clock edge of the caliper
// (data bit plus microsecond timestamp); one beat is taken every clock cycle,
// and in_ch.ready drops only while the four-entry frame queue between the edge
// tracker and the decode pipeline is full, which happens only when four closed
// frames wait behind a stalled output. A closed frame is written into the frame queue
// and then moves through the decode pipeline to out_ch; the decode pipeline has
// an inch-scaling multiply, a reciprocal multiply for the divide by 200, a
// quotient correction and the sign/error select, one stage each. Configuration
// writes (gap threshold, error value) take effect at once and belong to idle time.
module caliper_frame_decoder #(
	parameter int unsigned WORD_BITS = cfd_pkg::WORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfd_pkg::DATA_W-1:0]     cfg_wdata,
	cfd_stream_if.sink                     in_ch,
	cfd_stream_if.source                   out_ch
);

	logic [cfd_pkg::GAP_W-1:0]  gap_q;
	logic [cfd_pkg::DATA_W-1:0] err_q;

	logic                 push;
	logic                 pop;
	cfd_pkg::frame_rec_t  wr_rec;
	cfd_pkg::frame_rec_t  rd_rec;
	cfd_pkg::queue_stat_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= cfd_pkg::GAP_RESET;
			err_q <= cfd_pkg::ERR_RESET;
		end else if (cfg_we) begin
			case (cfd_pkg::cfg_reg_t'(cfg_index))
				cfd_pkg::REG_GAP: gap_q <= cfg_wdata[cfd_pkg::GAP_W-1:0];
				cfd_pkg::REG_ERR: err_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	cfd_front #(
		.WORD_BITS(WORD_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_ch            (in_ch),
		.gap_threshold_us (gap_q),
		.qstat            (qstat),
		.push             (push),
		.rec              (wr_rec)
	);

	cfd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_rec),
		.pop     (pop),
		.rd_data (rd_rec),
		.qstat   (qstat)
	);

	cfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_data     (rd_rec),
		.qstat       (qstat),
		.pop         (pop),
		.error_value (err_q),
		.out_ch      (out_ch)
	);

endmodule

### rtl/cfd_front.sv
`include "caliper_frame_decoder_defines.svh"

module cfd_front #(
	parameter int unsigned WORD_BITS = cfd_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	cfd_stream_if.sink                    in_ch,
	input  logic [cfd_pkg::GAP_W-1:0]     gap_threshold_us,
	input  cfd_pkg::queue_stat_t          qstat,
	output logic                          push,
	output cfd_pkg::frame_rec_t           rec
);

	localparam int unsigned POS_W = $clog2(WORD_BITS + 1);
	localparam int unsigned IDX_W = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] word_q;
	logic [POS_W-1:0]     pos_q;
	logic [31:0]          start_q;

	logic [WORD_BITS-1:0] word_upd;
	logic                 in_word;
	logic [31:0]          diff;
	logic                 accept;
	logic                 close;

	assign in_ch.ready = !qstat.full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign in_word     = pos_q < POS_W'(WORD_BITS);

	always_comb begin
		word_upd = word_q;
		if (in_word) begin
			word_upd[pos_q[IDX_W-1:0]] = word_q[pos_q[IDX_W-1:0]] | in_ch.payload.data_bit;
		end
	end

	assign diff  = in_ch.payload.timestamp_us - start_q;
	assign close = !diff[31] && (diff[30:0] > gap_threshold_us);
	assign push  = accept && close;

	always_comb begin
		rec.top_bit = word_upd[WORD_BITS-1];
		rec.inch    = word_upd[cfd_pkg::INCH_BIT];
		rec.sign    = word_upd[cfd_pkg::SIGN_BIT];
		rec.mag     = word_upd[cfd_pkg::MAG_BITS-1:0];
		rec.time_us = in_ch.payload.timestamp_us;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
		end else if (accept) begin
			if (close) begin
				word_q  <= '0;
				pos_q   <= '0;
				start_q <= in_ch.payload.timestamp_us;
			end else begin
				word_q <= word_upd;
				if (in_word) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	`CFD_ASSERT_NXT(a_close_clears, push, pos_q == '0 && word_q == '0)
	`CFD_ASSERT_NXT(a_pos_advances, accept && !push, pos_q != '0)

endmodule

### rtl/cfd_queue.sv
module cfd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cfd_pkg::frame_rec_t  wr_data,
	input  logic                 pop,
	output cfd_pkg::frame_rec_t  rd_data,
	output cfd_pkg::queue_stat_t qstat
);

	localparam int unsigned DEPTH = cfd_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cfd_pkg::frame_rec_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign rd_data     = mem_q[rd_ptr_q];
	assign qstat.full  = count_q == CNT_W'(DEPTH);
	assign qstat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### rtl/cfd_back.sv
`include "caliper_frame_decoder_defines.svh"

module cfd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfd_pkg::frame_rec_t         rd_data,
	input  cfd_pkg::queue_stat_t        qstat,
	output logic                        pop,
	input  logic [cfd_pkg::DATA_W-1:0]  error_value,
	cfd_stream_if.source                out_ch
);

	localparam int unsigned PROD_W   = cfd_pkg::PROD_W;
	localparam int unsigned DIVIN_W  = cfd_pkg::DIVIN_W;
	localparam int unsigned SCALED_W = cfd_pkg::SCALED_W;
	localparam int unsigned MUL_W    = DIVIN_W + 32;

	logic adv;

	logic                valid_s1;
	cfd_pkg::frame_rec_t rec_s1;
	logic [PROD_W-1:0]   prod_s1;

	logic                valid_s2;
	cfd_pkg::frame_rec_t rec_s2;
	logic [DIVIN_W-1:0]  y_s2;
	logic [SCALED_W-1:0] q0_s2;

	logic                valid_s3;
	cfd_pkg::frame_rec_t rec_s3;
	logic [SCALED_W-1:0] mag_s3;

	logic                out_valid_q;
	cfd_pkg::out_item_t  out_q;

	logic [DIVIN_W-1:0]  y_s1;
	logic [MUL_W-1:0]    recip_prod;
	logic [DIVIN_W:0]    rem_s2;
	logic [SCALED_W-1:0] q_fix;
	logic [31:0]         mag_ext;
	logic [31:0]         pos_val;

	assign adv = !out_valid_q || out_ch.ready;
	assign pop = adv && !qstat.empty;

	assign y_s1       = prod_s1[PROD_W-1:cfd_pkg::PRE_SHIFT];
	assign recip_prod = MUL_W'(y_s1) * MUL_W'(cfd_pkg::RECIP);

	assign rem_s2 = (DIVIN_W + 1)'(y_s2)
		- (DIVIN_W + 1)'(q0_s2) * (DIVIN_W + 1)'(cfd_pkg::DIV_REST);
	assign q_fix  = (rem_s2 >= (DIVIN_W + 1)'(cfd_pkg::DIV_REST)) ?
		q0_s2 + SCALED_W'(1) : q0_s2;

	assign mag_ext = 32'(mag_s3);
	assign pos_val = rec_s3.top_bit ? error_value :
		(rec_s3.sign ? 32'd0 - mag_ext : mag_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= !qstat.empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s1  <= rd_data;
			prod_s1 <= PROD_W'(rd_data.mag) * PROD_W'(cfd_pkg::INCH_NUM);

			rec_s2 <= rec_s1;
			y_s2   <= y_s1;
			q0_s2  <= SCALED_W'(recip_prod >> cfd_pkg::RECIP_SHIFT);

			rec_s3 <= rec_s2;
			mag_s3 <= rec_s2.inch ? q_fix : SCALED_W'(rec_s2.mag);

			out_q.position_um   <= pos_val;
			out_q.frame_time_us <= rec_s3.time_us;
			out_q.out_of_range  <= rec_s3.top_bit;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

	`CFD_ASSERT_IMP(a_err_value, out_ch.valid && out_ch.payload.out_of_range,
		out_ch.payload.position_um == error_value)

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned FRAME_BITS      = cfd_pkg::WORD_BITS_DEF;
	localparam int unsigned INCH_MUL        = 254;
	localparam int unsigned INCH_DIV        = 200;
	localparam int unsigned SETTLE_CYCLES   = 16;
	localparam int unsigned RAND_PHASES     = 8;
	localparam int unsigned EDGES_PER_PHASE = 250;
	localparam int unsigned CYCLE_LIMIT     = 500_000;
	localparam int unsigned PRINT_LIMIT     = 100;
	localparam logic [cfd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [cfd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef enum bit [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} exp_mode_t;
	typedef enum bit {ROW_FRAME, ROW_CFG} row_kind_t;

	// frame rows: edges carry bits[0..nbits-1]; the last edge lands at frame start + last_off
	// config rows: idx and bits[31:0] as write data
	typedef struct packed {
		row_kind_t    kind;
		logic [1:0]   idx;
		logic [39:0]  bits;
		logic [5:0]   nbits;
		logic [31:0]  step;
		logic [31:0]  last_off;
		exp_mode_t    mode;
		logic [31:0]  pos;
		logic         oor;
	} stim_row_t;

	localparam int DIR_ROWS = 24;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [cfd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [cfd_pkg::DATA_W-1:0]    cfg_wdata;

	cfd_stream_if #(.payload_t(cfd_pkg::in_item_t))  caliper_in ();
	cfd_stream_if #(.payload_t(cfd_pkg::out_item_t)) frame_out ();

	caliper_frame_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (caliper_in),
		.out_ch    (frame_out)
	);

	logic [31:0] cal_word;
	logic [5:0]  cal_bitpos;
	logic [31:0] cal_start;
	logic [30:0] cal_gap;
	logic [31:0] cal_err;

	cfd_pkg::out_item_t expected_frames[$];
	int unsigned        mismatch_count;
	int unsigned        edges_sent;
	int unsigned        cycle_count;
	int unsigned        sink_hold;
	bit                 src_steady;
	bit                 sink_steady;

	stim_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h1, 6'd1, 32'd0, 32'd0, EXP_NONE, 32'd0, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h0, 6'd1, 32'd0, 32'd90000, EXP_NONE,
			32'd0, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h0, 6'd1, 32'd0, 32'd90001, EXP_GIVEN,
			32'd1, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h0, 6'd1, 32'd0, 32'hFFFF_FFFF, EXP_NONE,
			32'd0, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h0, 6'd1, 32'd0, 32'h8000_0000, EXP_NONE,
			32'd0, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h0, 6'd1, 32'd0, 32'h7FFF_FFFF, EXP_GIVEN,
			32'd0, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h0F_FFFF, 6'd24, 32'd100, 32'd100000, EXP_GIVEN,
			32'd1048575, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h1F_FFFF, 6'd24, 32'd100, 32'd100000, EXP_GIVEN,
			-32'sd1048575, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h10_0000, 6'd24, 32'd100, 32'd100000, EXP_GIVEN,
			32'd0, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h8F_FFFF, 6'd24, 32'd100, 32'd100000, EXP_GIVEN,
			32'd1331690, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h9F_FFFF, 6'd24, 32'd100, 32'd100000, EXP_GIVEN,
			-32'sd1331690, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h90_0003, 6'd24, 32'd100, 32'd100000, EXP_MODEL,
			32'd0, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h8000_0000, 6'd32, 32'd100, 32'd100000,
			EXP_GIVEN, 32'h8000_0000, 1'b1},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'hFF_0000_0005, 6'd40, 32'd100, 32'd100000,
			EXP_GIVEN, 32'd5, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'hFF_FFFF_FFFF, 6'd40, 32'd100, 32'd100000,
			EXP_GIVEN, 32'h8000_0000, 1'b1},
		'{ROW_CFG, cfd_pkg::REG_GAP, 40'h7FFF_FFFF, 6'd0, 32'd0, 32'd0, EXP_NONE,
			32'd0, 1'b0},
		'{ROW_CFG, cfd_pkg::REG_ERR, 40'h7FFF_FFFF, 6'd0, 32'd0, 32'd0, EXP_NONE,
			32'd0, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h0, 6'd2, 32'h4000_0000, 32'h7FFF_FFFF,
			EXP_NONE, 32'd0, 1'b0},
		'{ROW_CFG, cfd_pkg::REG_GAP, 40'h0, 6'd0, 32'd0, 32'd0, EXP_NONE, 32'd0, 1'b0},
		'{ROW_CFG, cfd_pkg::REG_ERR, 40'h0, 6'd0, 32'd0, 32'd0, EXP_NONE, 32'd0, 1'b0},
		'{ROW_CFG, REG_SPARE_A, 40'hFFFF_FFFF, 6'd0, 32'd0, 32'd0, EXP_NONE, 32'd0, 1'b0},
		'{ROW_CFG, REG_SPARE_B, 40'hFFFF_FFFF, 6'd0, 32'd0, 32'd0, EXP_NONE, 32'd0, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'h1, 6'd1, 32'd0, 32'd1, EXP_MODEL, 32'd0, 1'b0},
		'{ROW_FRAME, cfd_pkg::REG_GAP, 40'hFFFF_FFFF, 6'd32, 32'd0, 32'd1, EXP_GIVEN,
			32'd0, 1'b1}
	};

	always #10 clk = ~clk;

	function automatic bit decode_caliper_edge(input bit b, input logic [31:0] ts,
			output cfd_pkg::out_item_t res);
		logic [31:0] elapsed;
		logic [31:0] mag;
		res = '0;
		if (cal_bitpos < FRAME_BITS) begin
			cal_word = cal_word | (32'(b) << cal_bitpos);
			cal_bitpos = cal_bitpos + 6'd1;
		end
		elapsed = ts - cal_start;
		if (elapsed[31] || elapsed <= {1'b0, cal_gap})
			return 1'b0;
		if (cal_word[FRAME_BITS-1]) begin
			res = '{position_um: cal_err, frame_time_us: ts, out_of_range: 1'b1};
		end else begin
			mag = {12'd0, cal_word[19:0]};
			if (cal_word[23])
				mag = mag * INCH_MUL / INCH_DIV;
			if (cal_word[20])
				mag = -mag;
			res = '{position_um: mag, frame_time_us: ts, out_of_range: 1'b0};
		end
		cal_start = ts;
		cal_bitpos = '0;
		cal_word = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("ERROR @%0t %s: got %h want %h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic write_reg(logic [cfd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cfd_pkg::REG_GAP: cal_gap = val[30:0];
			cfd_pkg::REG_ERR: cal_err = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain_frames();
		caliper_in.valid <= 1'b0;
		@(posedge clk);
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_frame(logic [39:0] bits, int unsigned n, logic [31:0] step,
			logic [31:0] last_off, exp_mode_t mode, logic [31:0] want_pos, bit want_oor);
		logic [31:0]        base;
		logic [31:0]        ts;
		cfd_pkg::out_item_t res;
		int unsigned        idle;
		bit                 closed;
		bit                 last;
		base = cal_start;
		for (int unsigned k = 0; k < n; k++) begin
			last = (k == n - 1);
			ts = last ? base + last_off : base + step * (k + 1);
			idle = src_steady ? 0 : $urandom_range(0, 9);
			if (idle != 0) begin
				caliper_in.valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			caliper_in.valid   <= 1'b1;
			caliper_in.payload <= '{data_bit: bits[k], timestamp_us: ts};
			do @(posedge clk); while (!caliper_in.ready);
			closed = decode_caliper_edge(bits[k], ts, res);
			if (last && mode == EXP_GIVEN)
				expected_frames.push_back(cfd_pkg::out_item_t'{position_um: want_pos,
					frame_time_us: ts, out_of_range: want_oor});
			else if (closed && !(last && mode == EXP_NONE))
				expected_frames.push_back(res);
			edges_sent++;
		end
	endtask

	// result side: random stall after every beat unless sink_steady is set
	always @(posedge clk) begin
		cfd_pkg::out_item_t got;
		cfd_pkg::out_item_t want;
		if (arst_n) begin
			if (frame_out.valid && frame_out.ready) begin
				got = frame_out.payload;
				if (expected_frames.size() == 0) begin
					report_mismatch("unexpected frame", got.frame_time_us, 32'd0);
				end else begin
					want = expected_frames.pop_front();
					if (got.position_um !== want.position_um)
						report_mismatch("position_um", got.position_um, want.position_um);
					if (got.frame_time_us !== want.frame_time_us)
						report_mismatch("frame_time_us", got.frame_time_us,
							want.frame_time_us);
					if (got.out_of_range !== want.out_of_range)
						report_mismatch("out_of_range", 32'(got.out_of_range),
							32'(want.out_of_range));
				end
				sink_hold = sink_steady ? 0 : $urandom_range(0, 9);
			end
			frame_out.ready <= (sink_hold == 0);
			if (sink_hold != 0)
				sink_hold--;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [39:0]     bits;
		int unsigned     n;
		logic [31:0]     step;
		logic [31:0]     off;
		logic [31:0]     gap_pick;
		logic [31:0]     err_pick;
		longint unsigned head;
		int unsigned     phase_start;

		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		caliper_in.valid   = 1'b0;
		caliper_in.payload = '0;
		frame_out.ready    = 1'b0;
		mismatch_count     = 0;
		edges_sent         = 0;
		cycle_count        = 0;
		sink_hold          = 0;
		src_steady         = 1'b0;
		sink_steady        = 1'b0;
		cal_word           = '0;
		cal_bitpos         = '0;
		cal_start          = '0;
		cal_gap            = 31'd90000;
		cal_err            = 32'h8000_0000;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain_frames();
				write_reg(dir_rows[i].idx, dir_rows[i].bits[31:0]);
			end else begin
				send_frame(dir_rows[i].bits, dir_rows[i].nbits, dir_rows[i].step,
					dir_rows[i].last_off, dir_rows[i].mode, dir_rows[i].pos,
					dir_rows[i].oor);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain_frames();
			case (ph % 6)
				0: gap_pick = 32'd90000;
				1: gap_pick = 32'd0;
				2: gap_pick = 32'd1;
				3: gap_pick = $urandom_range(2, 20000);
				4: gap_pick = $urandom_range(32'h4000_0000, 32'h7FFF_0000);
				default: gap_pick = $urandom_range(100, 2_000_000);
			endcase
			write_reg(cfd_pkg::REG_GAP, {1'($urandom_range(0, 1)), gap_pick[30:0]});
			case (ph % 4)
				0: err_pick = 32'h8000_0000;
				1: err_pick = 32'h7FFF_FFFF;
				2: err_pick = 32'hFFFF_FFFF;
				default: err_pick = $urandom;
			endcase
			write_reg(cfd_pkg::REG_ERR, err_pick);
			if (ph % 2 == 1)
				write_reg((ph % 4 == 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
			src_steady  = (ph == 1) || ($urandom_range(0, 4) == 0);
			sink_steady = (ph == 3) || ($urandom_range(0, 4) == 0);

			phase_start = edges_sent;
			while (edges_sent - phase_start < EDGES_PER_PHASE) begin
				if ($urandom_range(0, 7) != 0) begin
					n = ($urandom_range(0, 3) != 0) ? 24 : $urandom_range(1, 40);
					bits = {8'($urandom), 32'($urandom)};
					if ($urandom_range(0, 2) != 0)
						bits[31] = 1'b0;
					step = $urandom_range(0, 32'(cal_gap) / 48);
					head = 64'h7FFF_FFFF - cal_gap - 1;
					if (head > 100000)
						head = 100000;
					off = 32'(cal_gap) + 32'd1 + $urandom_range(0, 32'(head));
					send_frame(bits, n, step, off, EXP_MODEL, 32'd0, 1'b0);
				end else begin
					// stray edge: arbitrary time, a step back, or at or just past the threshold
					case ($urandom_range(0, 2))
						0: off = $urandom;
						1: off = 32'd0 - $urandom_range(1, 5000);
						default: off = 32'(cal_gap) + $urandom_range(0, 2);
					endcase
					send_frame({39'd0, 1'($urandom_range(0, 1))}, 1, 32'd0, off, EXP_MODEL,
						32'd0, 1'b0);
				end
			end
		end

		drain_frames();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
